/* sv/tpvs_pkg.sv */
// Shared constants, command and status types for the three-axis speed controller.
package tpvs_pkg;

	localparam int DivW = 73;
	localparam int DsrW = 36;
	localparam int NMotor = 3;

	localparam logic [2:0] REG_TPOS1  = 3'd0;
	localparam logic [2:0] REG_TPOS2  = 3'd1;
	localparam logic [2:0] REG_TPOS3  = 3'd2;
	localparam logic [2:0] REG_TVEL1  = 3'd3;
	localparam logic [2:0] REG_TVEL2  = 3'd4;
	localparam logic [2:0] REG_TVEL3  = 3'd5;
	localparam logic [2:0] REG_DIR    = 3'd6;
	localparam logic [2:0] REG_PERIOD = 3'd7;

	localparam logic       FUNC_START = 1'b0;
	localparam logic [1:0] CODE_FWD   = 2'b10;
	localparam logic [1:0] CODE_REV   = 2'b01;

	localparam logic [2:0]  DIR_RST    = 3'b111;
	localparam logic [19:0] PERIOD_RST = 20'd20000;

	localparam logic signed [32:0] STOP_WIN = 33'sd5;
	localparam logic [28:0] SPEED_K  = 29'd384000000;
	localparam logic [19:0] US_PER_S = 20'd1000000;
	localparam logic [40:0] STEP_MAX = {1'b1, 40'd0};
	localparam logic signed [41:0] INT_MAX = 42'sd549755813887;
	localparam logic signed [41:0] INT_MIN = -42'sd549755813888;
	localparam logic signed [69:0] DUTY_CEIL = 70'sd1310720;
	localparam logic [11:0] DIV5_K = 12'd3277;

	typedef struct packed {
		logic load;
		logic eval;
		logic go_upd;
		logic mul1;
		logic div1;
		logic err;
		logic mul2;
		logic div2;
		logic acc;
		logic duty;
		logic finish;
	} tpvs_cmd_t;

	typedef struct packed {
		logic is_start;
		logic stop_all;
		logic due;
		logic div_busy;
		logic last_motor;
	} tpvs_sts_t;

endpackage

/* sv/tpvs_div.sv */
// Restoring divider, one quotient bit per cycle.
module tpvs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tpvs_pkg::DivW-1:0]     dividend,
	input  logic [tpvs_pkg::DsrW-1:0]     divisor,
	output logic                          busy,
	output logic [tpvs_pkg::DivW-1:0]     quotient
);
	localparam int CntW = $clog2(tpvs_pkg::DivW + 1);

	logic [tpvs_pkg::DsrW-1:0] rem_q;
	logic [tpvs_pkg::DsrW-1:0] dsr_q;
	logic [tpvs_pkg::DivW-1:0] quo_q;
	logic [CntW-1:0]           cnt_q;
	logic                      busy_q;
	logic [tpvs_pkg::DsrW:0]   shifted;
	logic [tpvs_pkg::DsrW+1:0] diff;
	logic                      ge;

	assign shifted = {rem_q, quo_q[tpvs_pkg::DivW-1]};
	assign diff = {1'b0, shifted} - {2'b00, dsr_q};
	assign ge = !diff[tpvs_pkg::DsrW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CntW'(tpvs_pkg::DivW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[tpvs_pkg::DsrW-1:0] : shifted[tpvs_pkg::DsrW-1:0];
			quo_q <= {quo_q[tpvs_pkg::DivW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule

/* sv/tpvs_dp.sv */
// Datapath: configuration, controller state, speed and PI arithmetic, result word.
module tpvs_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  tpvs_pkg::tpvs_cmd_t cmd,
	output tpvs_pkg::tpvs_sts_t sts,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [31:0]         cfg_wdata,
	input  logic                func,
	input  logic signed [31:0]  pos_m1,
	input  logic signed [31:0]  pos_m2,
	input  logic signed [31:0]  pos_m3,
	input  logic [31:0]         now_us,
	output logic [7:0]          pwm_m1,
	output logic [7:0]          pwm_m2,
	output logic [7:0]          pwm_m3,
	output logic [7:0]          drive_code,
	output logic                running,
	output logic                updated
);
	logic [31:0] tpos_q [3];
	logic [15:0] tvel_q [3];
	logic [2:0]  dir_q;
	logic [19:0] per_q;

	logic [7:0]  mcode_q;
	logic [31:0] lpos_q [3];
	logic [31:0] ltime_q;
	logic [39:0] integ_q [3];
	logic [7:0]  held_q [3];

	logic        func_q;
	logic [31:0] pos_q [3];
	logic [31:0] now_q;
	logic        upd_q;
	logic [1:0]  idx_q;
	logic [tpvs_pkg::DivW-1:0] prod_q;
	logic [tpvs_pkg::DsrW-1:0] dsr_q;
	logic signed [63:0] e_q;
	logic        big_q;

	logic [7:0]  out_pwm_q [3];
	logic [7:0]  out_code_q;
	logic        out_run_q;
	logic        out_upd_q;

	logic [7:0]  start_code;
	logic [7:0]  keep_mask;
	logic [31:0] intv;
	logic [31:0] cur_pos, cur_lpos;
	logic [15:0] cur_tvel;
	logic [39:0] cur_integ;
	logic signed [32:0] dpos;
	logic [32:0] dmag;
	logic [60:0] p1;
	logic [35:0] intv11;
	logic [tpvs_pkg::DivW-1:0] quo;
	logic        div_busy;
	logic signed [63:0] e_new;
	logic [63:0] emag;
	logic [72:0] p2;
	logic [40:0] step_mag;
	logic signed [41:0] step_s, sum, sat;
	logic signed [69:0] e70, u;
	logic [10:0] x;
	logic [22:0] q5;
	logic [7:0]  duty;
	logic        stop_sample;

	always_comb begin
		start_code = '0;
		keep_mask = '1;
		for (int i = 0; i < tpvs_pkg::NMotor; i++) begin
			logic signed [32:0] d;
			d = $signed({pos_q[i][31], pos_q[i]}) - $signed({tpos_q[i][31], tpos_q[i]});
			start_code[2*i+1 +: 2] = dir_q[i] ? tpvs_pkg::CODE_FWD : tpvs_pkg::CODE_REV;
			if (d >= -tpvs_pkg::STOP_WIN && d <= tpvs_pkg::STOP_WIN)
				keep_mask[2*i+1 +: 2] = 2'b00;
		end
	end

	assign intv = now_q - ltime_q;
	assign stop_sample = (func_q != tpvs_pkg::FUNC_START) && (mcode_q == 8'd0);

	assign sts.is_start = (func_q == tpvs_pkg::FUNC_START);
	assign sts.stop_all = (mcode_q == 8'd0);
	assign sts.due = (intv != 32'd0) && (intv >= {12'd0, per_q});
	assign sts.div_busy = div_busy;
	assign sts.last_motor = (idx_q == 2'd2);

	assign cur_pos = pos_q[idx_q];
	assign cur_lpos = lpos_q[idx_q];
	assign cur_tvel = tvel_q[idx_q];
	assign cur_integ = integ_q[idx_q];

	// speed term: |dpos| * 384e6 over interval * 11
	assign dpos = $signed({cur_pos[31], cur_pos}) - $signed({cur_lpos[31], cur_lpos});
	assign dmag = dpos[32] ? 33'(-dpos) : 33'(dpos);
	assign p1 = dmag[31:0] * tpvs_pkg::SPEED_K;
	assign intv11 = {4'd0, intv} * 36'd11;

	assign e_new = $signed({{40{cur_tvel[15]}}, cur_tvel, 8'd0}) - $signed({3'd0, quo[60:0]});
	assign emag = e_q[63] ? 64'(-e_q) : 64'(e_q);
	assign p2 = emag[52:0] * tpvs_pkg::US_PER_S;

	// step saturates at 2^40; |e| >= 2^53 always exceeds that
	assign step_mag = (big_q || (|quo[72:40])) ? tpvs_pkg::STEP_MAX : {1'b0, quo[39:0]};
	assign step_s = e_q[63] ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
	assign sum = $signed({{2{cur_integ[39]}}, cur_integ}) + step_s;
	assign sat = (sum > tpvs_pkg::INT_MAX) ? tpvs_pkg::INT_MAX :
		(sum < tpvs_pkg::INT_MIN) ? tpvs_pkg::INT_MIN : sum;

	assign e70 = $signed({{6{e_q[63]}}, e_q});
	assign u = (e70 <<< 4) + (e70 <<< 3) + $signed({{30{cur_integ[39]}}, cur_integ});
	assign x = u[20:10];
	assign q5 = x * tpvs_pkg::DIV5_K;
	assign duty = u[69] ? 8'd0 : (u >= tpvs_pkg::DUTY_CEIL) ? 8'd255 : q5[21:14];

	tpvs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div1 | cmd.div2),
		.dividend (prod_q),
		.divisor  (dsr_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tpvs_pkg::NMotor; i++) begin
				tpos_q[i] <= '0;
				tvel_q[i] <= '0;
				lpos_q[i] <= '0;
				integ_q[i] <= '0;
				held_q[i] <= '0;
			end
			dir_q <= tpvs_pkg::DIR_RST;
			per_q <= tpvs_pkg::PERIOD_RST;
			mcode_q <= '0;
			ltime_q <= '0;
			upd_q <= 1'b0;
			idx_q <= '0;
			out_code_q <= '0;
			out_run_q <= 1'b0;
			out_upd_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					tpvs_pkg::REG_TPOS1:  tpos_q[0] <= cfg_wdata;
					tpvs_pkg::REG_TPOS2:  tpos_q[1] <= cfg_wdata;
					tpvs_pkg::REG_TPOS3:  tpos_q[2] <= cfg_wdata;
					tpvs_pkg::REG_TVEL1:  tvel_q[0] <= cfg_wdata[15:0];
					tpvs_pkg::REG_TVEL2:  tvel_q[1] <= cfg_wdata[15:0];
					tpvs_pkg::REG_TVEL3:  tvel_q[2] <= cfg_wdata[15:0];
					tpvs_pkg::REG_DIR:    dir_q <= cfg_wdata[2:0];
					tpvs_pkg::REG_PERIOD: per_q <= cfg_wdata[19:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				upd_q <= 1'b0;
				idx_q <= '0;
			end
			if (cmd.eval) begin
				if (func_q == tpvs_pkg::FUNC_START) mcode_q <= start_code;
				else mcode_q <= mcode_q & keep_mask;
			end
			if (cmd.go_upd) upd_q <= 1'b1;
			if (cmd.acc) integ_q[idx_q] <= sat[39:0];
			if (cmd.duty) begin
				held_q[idx_q] <= duty;
				lpos_q[idx_q] <= cur_pos;
				idx_q <= idx_q + 2'd1;
			end
			if (cmd.finish) begin
				if (stop_sample) begin
					for (int i = 0; i < tpvs_pkg::NMotor; i++) held_q[i] <= '0;
				end
				if (upd_q) ltime_q <= now_q;
				out_code_q <= mcode_q;
				out_run_q <= (mcode_q != 8'd0);
				out_upd_q <= upd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			pos_q[0] <= pos_m1;
			pos_q[1] <= pos_m2;
			pos_q[2] <= pos_m3;
			now_q <= now_us;
		end
		if (cmd.mul1) begin
			prod_q <= {12'd0, p1};
			dsr_q <= intv11;
		end
		if (cmd.err) e_q <= e_new;
		if (cmd.mul2) begin
			prod_q <= p2;
			dsr_q <= {4'd0, intv};
			big_q <= |emag[63:53];
		end
		if (cmd.finish) begin
			for (int i = 0; i < tpvs_pkg::NMotor; i++)
				out_pwm_q[i] <= stop_sample ? 8'd0 : held_q[i];
		end
	end

	assign pwm_m1 = out_pwm_q[0];
	assign pwm_m2 = out_pwm_q[1];
	assign pwm_m3 = out_pwm_q[2];
	assign drive_code = out_code_q;
	assign running = out_run_q;
	assign updated = out_upd_q;

	a_run_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_run_q == (out_code_q != 8'd0))
		else $error("running flag disagrees with drive code");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc || cmd.err) |-> !div_busy)
		else $error("quotient used while divider busy");

endmodule

/* sv/tpvs_ctrl.sv */
// Controller: sequences evaluation, per-motor speed/PI steps and result handoff.
module tpvs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output tpvs_pkg::tpvs_cmd_t cmd,
	input  tpvs_pkg::tpvs_sts_t sts
);
	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_EVAL = 13'b0000000000010,
		S_DEC  = 13'b0000000000100,
		S_MUL1 = 13'b0000000001000,
		S_DV1S = 13'b0000000010000,
		S_DV1W = 13'b0000000100000,
		S_ERR  = 13'b0000001000000,
		S_MUL2 = 13'b0000010000000,
		S_DV2S = 13'b0000100000000,
		S_DV2W = 13'b0001000000000,
		S_ACC  = 13'b0010000000000,
		S_DUTY = 13'b0100000000000,
		S_DONE = 13'b1000000000000
	} tpvs_state_t;

	tpvs_state_t state_q, state_d;
	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				if (sts.is_start || sts.stop_all || !sts.due) begin
					state_d = S_DONE;
				end else begin
					cmd.go_upd = 1'b1;
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = S_DV1S;
			end
			S_DV1S: begin
				cmd.div1 = 1'b1;
				state_d = S_DV1W;
			end
			S_DV1W: if (!sts.div_busy) state_d = S_ERR;
			S_ERR: begin
				cmd.err = 1'b1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = S_DV2S;
			end
			S_DV2S: begin
				cmd.div2 = 1'b1;
				state_d = S_DV2W;
			end
			S_DV2W: if (!sts.div_busy) state_d = S_ACC;
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_DUTY;
			end
			S_DUTY: begin
				cmd.duty = 1'b1;
				state_d = sts.last_motor ? S_DONE : S_MUL1;
			end
			S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == S_EVAL)
		else $error("accepted word not evaluated");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || !out_stall))
		else $error("result overwrites a stalled word");
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("output valid raised outside finish");

endmodule

/* sv/three_axis_pi_velocity_with_stop.sv */
// Top level of the three-motor PI speed controller with position stop.
// Start words, stopped samples and samples before the period go from evaluation and
// decision straight to finish. An updating sample makes, per motor, two passes of the
// one shared restoring divider (speed, then integral step). One word is worked at a
// time; the next is taken while the result waits. Asynchronous active-low reset clears
// control and config state, not PWM or work registers; period to 20000, directions to 7.
module three_axis_pi_velocity_with_stop (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic signed [31:0] pos_m1,
	input  logic signed [31:0] pos_m2,
	input  logic signed [31:0] pos_m3,
	input  logic [31:0]        now_us,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         pwm_m1,
	output logic [7:0]         pwm_m2,
	output logic [7:0]         pwm_m3,
	output logic [7:0]         drive_code,
	output logic               running,
	output logic               updated
);
	tpvs_pkg::tpvs_cmd_t cmd;
	tpvs_pkg::tpvs_sts_t sts;

	tpvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	tpvs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.func       (func),
		.pos_m1     (pos_m1),
		.pos_m2     (pos_m2),
		.pos_m3     (pos_m3),
		.now_us     (now_us),
		.pwm_m1     (pwm_m1),
		.pwm_m2     (pwm_m2),
		.pwm_m3     (pwm_m3),
		.drive_code (drive_code),
		.running    (running),
		.updated    (updated)
	);

endmodule
